// ----- hw/rtl/hkq_pkg.sv -----
// shared types, constants and the key translation function for the keyboard report decoder
// no dependencies; used by hkq_ctrl, hkq_datapath and the top level
package hkq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int NKEYS = 6;
  localparam int IDX_W = 3;

  // command codes
  localparam logic CMD_REPORT = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // usage codes
  localparam logic [7:0] KEY_LAST_RSVD = 8'd3;
  localparam logic [7:0] KEY_A         = 8'd4;
  localparam logic [7:0] KEY_Z         = 8'd29;
  localparam logic [7:0] KEY_1         = 8'd30;
  localparam logic [7:0] KEY_9         = 8'd38;
  localparam logic [7:0] KEY_0         = 8'd39;
  localparam logic [7:0] KEY_ENTER     = 8'd40;
  localparam logic [7:0] KEY_BKSP      = 8'd42;
  localparam logic [7:0] KEY_TAB       = 8'd43;
  localparam logic [7:0] KEY_SPACE     = 8'd44;
  localparam logic [7:0] KEY_CAPS      = 8'd57;
  localparam logic [7:0] KEY_SCROLL    = 8'd71;
  localparam logic [7:0] KEY_RIGHT     = 8'd79;
  localparam logic [7:0] KEY_UP_LAST   = 8'd82;
  localparam logic [7:0] KEY_NUM       = 8'd83;

  localparam logic [7:0] MOD_SHIFT_MASK = 8'h22;
  localparam logic [6:0] CASE_OFFSET    = 7'h20;
  localparam logic [7:0] LETTER_BIAS    = 8'd93;  // 'a' - KEY_A
  localparam logic [7:0] DIGIT_BIAS     = 8'd19;  // '1' - KEY_1
  localparam logic [6:0] ASCII_ZERO     = 7'h30;
  localparam logic [6:0] ASCII_CR       = 7'h0D;
  localparam logic [6:0] ASCII_BS       = 7'h08;
  localparam logic [6:0] ASCII_TAB      = 7'h09;
  localparam logic [6:0] ASCII_SPACE    = 7'h20;

  // arrow keys right, left, down, up map to these scan codes
  localparam logic [2:0] ARROW_SCAN [4] = '{3'd3, 3'd4, 3'd1, 3'd2};

  typedef struct packed {
    logic [2:0] toggle;
    logic [5:0] shift;
    logic [2:0] scan;
    logic [6:0] ch;
  } entry_t;

  typedef struct packed {
    logic [6:0] ch;
    logic [2:0] scan;
  } xlat_t;

  typedef struct packed {
    logic       capture;
    logic       scan_step;
    logic       pop;
    logic       commit_prev;
    logic       load_out;
    logic [1:0] out_status;
  } dp_cmd_t;

  typedef struct packed {
    logic is_read;
    logic fifo_empty;
    logic step_full;
    logic last_idx;
  } dp_stat_t;

  function automatic xlat_t translate(input logic [7:0] code, input logic upper);
    xlat_t      r;
    logic [7:0] off;
    r.ch   = '0;
    r.scan = '0;
    off    = code - KEY_RIGHT;
    if (code >= KEY_A && code <= KEY_Z) begin
      r.ch = 7'(code + LETTER_BIAS);
      if (upper) r.ch = r.ch - CASE_OFFSET;
    end else if (code >= KEY_1 && code <= KEY_9) begin
      r.ch = 7'(code + DIGIT_BIAS);
    end else if (code == KEY_0) begin
      r.ch = ASCII_ZERO;
    end else if (code == KEY_ENTER) begin
      r.ch = ASCII_CR;
    end else if (code == KEY_BKSP) begin
      r.ch = ASCII_BS;
    end else if (code == KEY_TAB) begin
      r.ch = ASCII_TAB;
    end else if (code == KEY_SPACE) begin
      r.ch = ASCII_SPACE;
    end else if (code >= KEY_RIGHT && code <= KEY_UP_LAST) begin
      r.scan = ARROW_SCAN[off[1:0]];
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/hkq_ctrl.sv -----
// controller state machine for the keyboard report decoder
// depends on hkq_pkg for command and status structs and status codes
module hkq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  input  hkq_pkg::dp_stat_t stat,
  output hkq_pkg::dp_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state, state_next;
  logic [1:0] res_status, res_status_next;
  logic       rsp_valid_next;
  logic       out_free;

  assign req_stall = (state != S_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;

  always_comb begin
    state_next      = state;
    res_status_next = res_status;
    cmd             = '0;
    cmd.out_status  = res_status;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = stat.is_read ? S_READ : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.step_full) begin
          res_status_next = hkq_pkg::ST_FULL;
          state_next      = S_DONE;
        end else if (stat.last_idx) begin
          cmd.commit_prev = 1'b1;
          res_status_next = hkq_pkg::ST_OK;
          state_next      = S_DONE;
        end
      end
      S_READ: begin
        if (stat.fifo_empty) begin
          res_status_next = hkq_pkg::ST_EMPTY;
        end else begin
          cmd.pop         = 1'b1;
          res_status_next = hkq_pkg::ST_OK;
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        // wait for room in the output register
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign rsp_valid_next = cmd.load_out || (rsp_valid && rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_status <= hkq_pkg::ST_OK;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      res_status <= res_status_next;
      rsp_valid  <= rsp_valid_next;
    end
  end

endmodule

// ----- hw/rtl/hkq_datapath.sv -----
// datapath: latched report, previous keys, lock toggles, key queue memory and result register
// depends on hkq_pkg for types, constants and the translate function
module hkq_datapath (
  input  logic             clk,
  input  logic             rst,
  input  hkq_pkg::dp_cmd_t cmd,
  output hkq_pkg::dp_stat_t stat,
  input  logic             command,
  input  logic [7:0]       modifiers,
  input  logic [7:0]       key_code_0,
  input  logic [7:0]       key_code_1,
  input  logic [7:0]       key_code_2,
  input  logic [7:0]       key_code_3,
  input  logic [7:0]       key_code_4,
  input  logic [7:0]       key_code_5,
  output logic [1:0]       status,
  output logic [6:0]       char_out,
  output logic [2:0]       scan_out,
  output logic [5:0]       shift_out,
  output logic [2:0]       toggle_out
);

  logic [7:0] keys      [hkq_pkg::NKEYS];
  logic [7:0] prev_keys [hkq_pkg::NKEYS];
  logic [7:0] mods;
  logic       cmd_q;
  logic       popped;
  logic [hkq_pkg::IDX_W-1:0] idx;

  logic caps_on, num_on, scroll_on;
  logic caps_new, num_new, scroll_new;

  logic [hkq_pkg::PTR_W-1:0] head, head_next;
  logic [hkq_pkg::CNT_W-1:0] count;
  logic [hkq_pkg::SUM_W-1:0] wr_sum, wr_wrap;
  logic [hkq_pkg::PTR_W-1:0] wr_addr;

  hkq_pkg::entry_t mem [hkq_pkg::QUEUE_DEPTH];
  hkq_pkg::entry_t rd_data;
  hkq_pkg::entry_t wr_entry;
  hkq_pkg::xlat_t  xl;

  logic [7:0] code;
  logic       seen;
  logic       new_press;
  logic       needs_slot;
  logic       fifo_full;
  logic       do_push;

  assign code = keys[idx];

  always_comb begin
    seen = 1'b0;
    for (int i = 0; i < hkq_pkg::NKEYS; i++) begin
      if (prev_keys[i] == code) seen = 1'b1;
    end
  end

  assign new_press  = (code > hkq_pkg::KEY_LAST_RSVD) && !seen;
  assign caps_new   = caps_on   ^ (new_press && code == hkq_pkg::KEY_CAPS);
  assign num_new    = num_on    ^ (new_press && code == hkq_pkg::KEY_NUM);
  assign scroll_new = scroll_on ^ (new_press && code == hkq_pkg::KEY_SCROLL);

  assign xl = hkq_pkg::translate(code,
                ((mods & hkq_pkg::MOD_SHIFT_MASK) != 8'd0) != caps_new);

  assign needs_slot = new_press && (xl.ch != '0 || xl.scan != '0);
  assign fifo_full  = (count == hkq_pkg::CNT_W'(hkq_pkg::QUEUE_DEPTH));
  assign do_push    = cmd.scan_step && needs_slot && !fifo_full;

  assign wr_entry.toggle = {caps_new, num_new, scroll_new};
  assign wr_entry.shift  = {mods[6:4], mods[2:0]};
  assign wr_entry.scan   = xl.scan;
  assign wr_entry.ch     = xl.ch;

  // tail slot is head plus fill count, wrapped once
  assign wr_sum  = hkq_pkg::SUM_W'(head) + hkq_pkg::SUM_W'(count);
  assign wr_wrap = (wr_sum >= hkq_pkg::SUM_W'(hkq_pkg::QUEUE_DEPTH))
                 ? wr_sum - hkq_pkg::SUM_W'(hkq_pkg::QUEUE_DEPTH) : wr_sum;
  assign wr_addr = wr_wrap[hkq_pkg::PTR_W-1:0];

  assign head_next = (head == hkq_pkg::PTR_W'(hkq_pkg::QUEUE_DEPTH - 1))
                   ? '0 : head + 1'b1;

  assign stat.is_read    = (command == hkq_pkg::CMD_READ);
  assign stat.fifo_empty = (count == '0);
  assign stat.step_full  = needs_slot && fifo_full;
  assign stat.last_idx   = (idx == hkq_pkg::IDX_W'(hkq_pkg::NKEYS - 1));

  // captured report
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      keys[0] <= key_code_0;
      keys[1] <= key_code_1;
      keys[2] <= key_code_2;
      keys[3] <= key_code_3;
      keys[4] <= key_code_4;
      keys[5] <= key_code_5;
      mods    <= modifiers;
      cmd_q   <= command;
    end
  end

  // queue memory
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_addr] <= wr_entry;
    if (cmd.pop) rd_data <= mem[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      popped    <= 1'b0;
      caps_on   <= 1'b0;
      num_on    <= 1'b0;
      scroll_on <= 1'b0;
      head      <= '0;
      count     <= '0;
      for (int i = 0; i < hkq_pkg::NKEYS; i++) prev_keys[i] <= '0;
    end else begin
      if (cmd.capture) begin
        idx    <= '0;
        popped <= 1'b0;
      end
      if (cmd.scan_step) begin
        idx       <= idx + 1'b1;
        caps_on   <= caps_new;
        num_on    <= num_new;
        scroll_on <= scroll_new;
      end
      if (do_push) count <= count + 1'b1;
      if (cmd.pop) begin
        head   <= head_next;
        count  <= count - 1'b1;
        popped <= 1'b1;
      end
      if (cmd.commit_prev) begin
        for (int i = 0; i < hkq_pkg::NKEYS; i++) prev_keys[i] <= keys[i];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status <= cmd.out_status;
      if (popped && cmd_q == hkq_pkg::CMD_READ) begin
        char_out   <= rd_data.ch;
        scan_out   <= rd_data.scan;
        shift_out  <= rd_data.shift;
        toggle_out <= rd_data.toggle;
      end else begin
        char_out   <= '0;
        scan_out   <= '0;
        shift_out  <= '0;
        toggle_out <= '0;
      end
    end
  end

endmodule

// ----- hw/rtl/hid_keyboard_report_to_key_queue_core.sv -----
// keyboard report decoder top level: a report is handled as capture, then one key code per cycle
// over the six codes (stopping early when the queue is full), then result load; a read is handled
// as capture, queue memory read, then result load. the result load waits while the output
// register still holds a stalled result. the result waits in an output register, so a new item
// is taken while it is still stalled. reset clears the lock toggles, previous keys, queue
// pointers and handshake state; the queue memory is not cleared.
module hid_keyboard_report_to_key_queue_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic       command,
  input  logic [7:0] modifiers,
  input  logic [7:0] key_code_0,
  input  logic [7:0] key_code_1,
  input  logic [7:0] key_code_2,
  input  logic [7:0] key_code_3,
  input  logic [7:0] key_code_4,
  input  logic [7:0] key_code_5,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output logic [1:0] status,
  output logic [6:0] char_out,
  output logic [2:0] scan_out,
  output logic [5:0] shift_out,
  output logic [2:0] toggle_out
);

  hkq_pkg::dp_cmd_t  cmd;
  hkq_pkg::dp_stat_t stat;

  hkq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  hkq_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .command    (command),
    .modifiers  (modifiers),
    .key_code_0 (key_code_0),
    .key_code_1 (key_code_1),
    .key_code_2 (key_code_2),
    .key_code_3 (key_code_3),
    .key_code_4 (key_code_4),
    .key_code_5 (key_code_5),
    .status     (status),
    .char_out   (char_out),
    .scan_out   (scan_out),
    .shift_out  (shift_out),
    .toggle_out (toggle_out)
  );

endmodule
